[rtl/core/fab_pkg.sv]
// ----------------------------------------------------------------------------
// fab_pkg
// Shared widths, defaults and types of the adaptive beamformer.
// ----------------------------------------------------------------------------
package fab_pkg;

  localparam int TAPS_DEF   = 16;
  localparam int MICS_DEF   = 4;
  localparam int NUM_INPUTS = 4;
  localparam int SAMPLE_W   = 24;
  localparam int WEIGHT_W   = 32;
  localparam int STEP_W     = 16;
  localparam int OUT_W      = 32;
  localparam int ACC_W      = 64;

  localparam logic [STEP_W-1:0] STEP_RESET = 16'd256;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [WEIGHT_W-1:0] weight_t;

  // handshake between the sequencer and the mean divider
  typedef struct packed {
    logic start;
    logic done;
  } div_ctrl_t;

endpackage

[rtl/core/fab_ram.sv]
// ----------------------------------------------------------------------------
// fab_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module fab_ram
  import fab_pkg::*;
#(
  parameter int WIDTH = WEIGHT_W,
  parameter int DEPTH = TAPS_DEF * MICS_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/core/fab_div.sv]
// ----------------------------------------------------------------------------
// fab_div
// Division of a signed sum by the constant microphone count, quotient
// truncated toward zero, by reciprocal multiplication with registered products.
// ----------------------------------------------------------------------------
module fab_div
  import fab_pkg::*;
#(
  parameter int DIVISOR = MICS_DEF,
  parameter int DW      = WEIGHT_W + $clog2(MICS_DEF)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [DW-1:0] dividend,
  output logic                 done,
  output weight_t              quotient
);

  // floor(n * RECIP / 2^SH) equals floor(n / DIVISOR) for every n below 2^DW
  localparam int     SH      = DW + $clog2(DIVISOR);
  localparam int     HW      = (DW + 2) / 2;
  localparam int     PW      = 4 * HW;
  localparam longint RECIP_L = ((longint'(1) <<< SH) + longint'(DIVISOR) - longint'(1))
                               / longint'(DIVISOR);
  localparam logic [2*HW-1:0] RECIP = (2*HW)'(RECIP_L);

  logic                stage;
  logic                neg;
  logic [DW-1:0]       abs_in;
  logic [2*HW-1:0]     mag;
  logic [2*HW-1:0]     p_ll;
  logic [2*HW-1:0]     p_lh;
  logic [2*HW-1:0]     p_hl;
  logic [2*HW-1:0]     p_hh;
  logic [PW-1:0]       total;
  logic [WEIGHT_W-1:0] quo_w;

  assign abs_in   = dividend[DW-1] ? DW'(~dividend + DW'(1)) : DW'(dividend);
  assign total    = PW'(p_ll) + (PW'(p_lh) << HW) + (PW'(p_hl) << HW)
                  + (PW'(p_hh) << (2 * HW));
  assign quo_w    = WEIGHT_W'(total >> SH);
  assign quotient = neg ? weight_t'(~quo_w + WEIGHT_W'(1)) : weight_t'(quo_w);

  always_ff @(posedge clk) begin
    if (rst) begin
      stage <= 1'b0;
      done  <= 1'b0;
    end else begin
      stage <= start;
      done  <= stage;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[DW-1];
      mag <= (2*HW)'(abs_in);
    end
    // split both operands so each product stays narrow
    if (stage) begin
      p_ll <= mag[HW-1:0] * RECIP[HW-1:0];
      p_lh <= mag[HW-1:0] * RECIP[2*HW-1:HW];
      p_hl <= mag[2*HW-1:HW] * RECIP[HW-1:0];
      p_hh <= mag[2*HW-1:HW] * RECIP[2*HW-1:HW];
    end
  end

endmodule

[rtl/core/frost_adaptive_beamformer.sv]
// ----------------------------------------------------------------------------
// frost_adaptive_beamformer
// Frost constrained-LMS beamformer: dot product of weights and tap history,
// then the projected weight update W = P(W - mu*y*x) + f.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake             Payload
// cfg       in   cfg_valid/cfg_ready   cfg_data (step_size, 16 bit unsigned)
// in        in   in_valid/in_ready     mic_a .. mic_d (24 bit signed)
// out       out  out_valid/out_ready   beam_sample (32 bit signed)
//
// Sequencing: one transaction at a time. A warmup item stores the samples
// and finishes. An adapting item stores them, runs the dot product over
// every tap, then per tap reads the weight and tap of each microphone,
// waits for the mean from the divider and writes the weights back; the
// single read port of each memory makes every read a step of its own.
// Reset: synchronous, active high; clears control state and the weight
// epoch bit, so the weight memory needs no clearing pass.
// Stalls: a finished result waits in the output register; the next input
// transaction is taken while it waits, and the next result holds in the
// last state until the earlier one is taken.
// ----------------------------------------------------------------------------
module frost_adaptive_beamformer
  import fab_pkg::*;
#(
  parameter int TAPS = TAPS_DEF,
  parameter int MICS = MICS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [STEP_W-1:0]          cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] mic_a,
  input  logic signed [SAMPLE_W-1:0] mic_b,
  input  logic signed [SAMPLE_W-1:0] mic_c,
  input  logic signed [SAMPLE_W-1:0] mic_d,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [OUT_W-1:0]    beam_sample
);

  localparam int N    = MICS * TAPS;
  localparam int AW   = $clog2(N);
  localparam int TW   = $clog2(TAPS);
  localparam int MW   = $clog2(MICS);
  localparam int SUMW = WEIGHT_W + MW;
  localparam int WCW  = $clog2(TAPS + 1);
  localparam int BIAS = (1 << 30) / MICS;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LOAD  = 4'd1;
  localparam logic [3:0] S_DOT   = 4'd2;
  localparam logic [3:0] S_YCALC = 4'd3;
  localparam logic [3:0] S_ECALC = 4'd4;
  localparam logic [3:0] S_ARD   = 4'd5;
  localparam logic [3:0] S_ADIV  = 4'd6;
  localparam logic [3:0] S_AWR   = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;

  // Pick the input sample of one microphone; extra microphones get zero.
  function automatic sample_t pick_mic(input int m, input sample_t a, input sample_t b,
                                       input sample_t c, input sample_t d);
    sample_t r;
    case (m)
      0:       r = a;
      1:       r = b;
      2:       r = c;
      3:       r = d;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Saturate a 64-bit value to the signed 32-bit range.
  function automatic weight_t sat32(input logic signed [63:0] v);
    weight_t r;
    if (v[63:31] == '0 || v[63:31] == '1) begin
      r = v[31:0];
    end else begin
      r = v[63] ? weight_t'(32'h8000_0000) : weight_t'(32'h7FFF_FFFF);
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Control state
  // --------------------------------------------------------------------------
  logic [3:0]      state;
  logic [MW-1:0]   mic_cnt;
  logic [TW-1:0]   tap_cnt;
  logic [TW-1:0]   head;        // position of tap 0 in each history ring
  logic [WCW-1:0]  warm_cnt;
  logic            weights_live;
  logic            iss_done;
  logic [2:0]      pv;          // read pipeline valid bits
  logic [MW-1:0]   vcnt;
  logic [STEP_W-1:0] step_size;

  // payload registers
  sample_t                   smp [MICS];
  logic signed [ACC_W-1:0]   acc;
  logic signed [55:0]        prod;
  weight_t                   y;
  logic signed [47:0]        e;
  logic signed [59:0]        ph;
  logic signed [60:0]        pl;
  weight_t                   wq1;
  weight_t                   wq2;
  logic signed [62:0]        d;
  weight_t                   v [MICS];
  logic signed [SUMW-1:0]    sum;
  weight_t                   mean;
  weight_t                   res;

  // --------------------------------------------------------------------------
  // Addressing: the tap history is a ring per microphone, weights are flat
  // --------------------------------------------------------------------------
  logic [TW:0]   ring_sum;
  logic [TW-1:0] ring_idx;
  logic [AW-1:0] mic_base;
  logic [AW-1:0] tap_rd_addr;
  logic [AW-1:0] wt_addr;
  logic [AW-1:0] tap_wr_addr;

  assign ring_sum    = {1'b0, head} + {1'b0, tap_cnt};
  assign ring_idx    = (ring_sum >= (TW+1)'(TAPS)) ? TW'(ring_sum - (TW+1)'(TAPS))
                                                   : ring_sum[TW-1:0];
  assign mic_base    = AW'(mic_cnt * TAPS);
  assign tap_rd_addr = mic_base + AW'(ring_idx);
  assign wt_addr     = mic_base + AW'(tap_cnt);
  assign tap_wr_addr = mic_base + AW'(head);

  // --------------------------------------------------------------------------
  // Memories
  // --------------------------------------------------------------------------
  logic                tap_we;
  logic                wt_we;
  logic [SAMPLE_W-1:0] tap_q;
  logic [WEIGHT_W-1:0] wt_q;
  weight_t             wt_new;
  sample_t             x_rd;
  weight_t             w_rd;

  assign tap_we = (state == S_LOAD);
  assign wt_we  = (state == S_AWR);

  fab_ram #(.WIDTH(SAMPLE_W), .DEPTH(N)) u_tap_ram (
    .clk     (clk),
    .wr_en   (tap_we),
    .wr_addr (tap_wr_addr),
    .wr_data (smp[mic_cnt]),
    .rd_addr (tap_rd_addr),
    .rd_data (tap_q)
  );

  fab_ram #(.WIDTH(WEIGHT_W), .DEPTH(N)) u_wt_ram (
    .clk     (clk),
    .wr_en   (wt_we),
    .wr_addr (wt_addr),
    .wr_data (wt_new),
    .rd_addr (wt_addr),
    .rd_data (wt_q)
  );

  // Until the first adaptation pass completes, every weight reads as zero.
  assign x_rd = sample_t'(tap_q);
  assign w_rd = weights_live ? weight_t'(wt_q) : '0;

  // --------------------------------------------------------------------------
  // Mean divider
  // --------------------------------------------------------------------------
  div_ctrl_t div_ctrl;
  weight_t   div_q;
  logic      issue;
  logic      mic_last;
  logic      tap_last;

  assign mic_last = (mic_cnt == MW'(MICS - 1));
  assign tap_last = (tap_cnt == TW'(TAPS - 1));
  assign issue    = (state == S_DOT || state == S_ARD) && !iss_done;
  assign div_ctrl.start = (state == S_ARD) && iss_done && (pv == '0);

  fab_div #(.DIVISOR(MICS), .DW(SUMW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_ctrl.start),
    .dividend (sum),
    .done     (div_ctrl.done),
    .quotient (div_q)
  );

  // --------------------------------------------------------------------------
  // Datapath arithmetic
  // --------------------------------------------------------------------------
  logic signed [ACC_W:0]   acc_sum;
  logic signed [ACC_W-1:0] acc_sat;
  logic signed [48:0]      e_full;
  weight_t                 v_new;
  logic signed [33:0]      nw;

  assign acc_sum = {acc[ACC_W-1], acc} + (ACC_W+1)'(prod);
  assign acc_sat = (acc_sum[ACC_W] == acc_sum[ACC_W-1]) ? acc_sum[ACC_W-1:0]
                 : (acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}});
  assign e_full  = y * $signed({1'b0, step_size});
  assign v_new   = sat32(64'(wq2) - 64'(d));
  assign nw      = 34'(v[mic_cnt]) - 34'(mean) + ((tap_cnt == '0) ? 34'(BIAS) : 34'(0));
  assign wt_new  = sat32(64'(nw));

  assign cfg_ready   = !rst;
  assign in_ready    = (state == S_IDLE) && !rst;

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      mic_cnt      <= '0;
      tap_cnt      <= '0;
      head         <= '0;
      warm_cnt     <= '0;
      weights_live <= 1'b0;
      iss_done     <= 1'b0;
      pv           <= '0;
      vcnt         <= '0;
      step_size    <= STEP_RESET;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        step_size <= cfg_data;
      end
      // drop the taken result unless a new one is loaded this cycle
      if (out_valid && out_ready && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end
      pv <= {pv[1:0], issue};

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            // back the ring up one slot: the new sample becomes tap 0
            head    <= (head == '0) ? TW'(TAPS - 1) : head - TW'(1);
            mic_cnt <= '0;
            state   <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (mic_last) begin
            mic_cnt  <= '0;
            tap_cnt  <= '0;
            iss_done <= 1'b0;
            if (warm_cnt < WCW'(TAPS)) begin
              warm_cnt <= warm_cnt + WCW'(1);
              state    <= S_FIN;
            end else begin
              state <= S_DOT;
            end
          end else begin
            mic_cnt <= mic_cnt + MW'(1);
          end
        end
        S_DOT: begin
          if (issue) begin
            if (tap_last) begin
              tap_cnt <= '0;
              if (mic_last) begin
                iss_done <= 1'b1;
              end else begin
                mic_cnt <= mic_cnt + MW'(1);
              end
            end else begin
              tap_cnt <= tap_cnt + TW'(1);
            end
          end else if (pv == '0) begin
            state <= S_YCALC;
          end
        end
        S_YCALC: begin
          state <= S_ECALC;
        end
        S_ECALC: begin
          mic_cnt  <= '0;
          tap_cnt  <= '0;
          iss_done <= 1'b0;
          vcnt     <= '0;
          state    <= S_ARD;
        end
        S_ARD: begin
          if (issue) begin
            if (mic_last) begin
              iss_done <= 1'b1;
            end else begin
              mic_cnt <= mic_cnt + MW'(1);
            end
          end else if (pv == '0) begin
            state <= S_ADIV;
          end
          if (pv[2]) begin
            vcnt <= vcnt + MW'(1);
          end
        end
        S_ADIV: begin
          if (div_ctrl.done) begin
            mic_cnt <= '0;
            state   <= S_AWR;
          end
        end
        S_AWR: begin
          if (mic_last) begin
            mic_cnt  <= '0;
            iss_done <= 1'b0;
            vcnt     <= '0;
            if (tap_last) begin
              weights_live <= 1'b1;
              state        <= S_FIN;
            end else begin
              tap_cnt <= tap_cnt + TW'(1);
              state   <= S_ARD;
            end
          end else begin
            mic_cnt <= mic_cnt + MW'(1);
          end
        end
        S_FIN: begin
          // hold the result until the output register is free
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      for (int i = 0; i < MICS; i++) begin
        smp[i] <= pick_mic(i, mic_a, mic_b, mic_c, mic_d);
      end
    end

    if (state == S_LOAD) begin
      acc <= '0;
      res <= '0;
    end

    // dot product: multiply, then accumulate with saturation
    if (state == S_DOT && pv[0]) begin
      prod <= w_rd * x_rd;
    end
    if (state == S_DOT && pv[1]) begin
      acc <= acc_sat;
    end

    if (state == S_YCALC) begin
      y <= sat32(acc >>> 30);
    end
    if (state == S_ECALC) begin
      e <= e_full[47:0];
      sum <= '0;
    end

    // gradient step: split the tap so each product stays narrow
    if (state == S_ARD && pv[0]) begin
      ph  <= e * $signed(x_rd[SAMPLE_W-1:12]);
      pl  <= e * $signed({1'b0, x_rd[11:0]});
      wq1 <= w_rd;
    end
    if (state == S_ARD && pv[1]) begin
      d   <= 63'($signed({ph, 2'b00})) + 63'(pl >>> 10);
      wq2 <= wq1;
    end
    if (state == S_ARD && pv[2]) begin
      v[vcnt] <= v_new;
      sum     <= sum + SUMW'(v_new);
    end

    if (state == S_ADIV && div_ctrl.done) begin
      mean <= div_q;
    end
    if (state == S_AWR && mic_last) begin
      sum <= '0;
      if (tap_last) begin
        res <= y;
      end
    end

    if (state == S_FIN && (!out_valid || out_ready)) begin
      beam_sample <= res;
    end
  end

`ifndef SYNTH
  // one transaction at a time: no second accept right after the first
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted twice in a row");

  // weights change only once the history is full
  a_adapt_after_warmup: assert property (@(posedge clk) disable iff (rst)
    wt_we |-> (warm_cnt == WCW'(TAPS)))
    else $error("weight write during warmup");

  // the divider answers only while the sequencer waits for it
  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_ctrl.done |-> (state == S_ADIV))
    else $error("divider finished outside its wait state");
`endif

endmodule
